@@ hw/rtl/btcs_pkg.sv @@
// Shared types and constants for the barycentric triangle colour shader.
// Depends on nothing; every other file of the block imports it.
package btcs_pkg;

  // Fixed field widths.
  localparam int CORNER_W   = 17;
  localparam int EDGE_W     = CORNER_W + 1;
  localparam int PIX_IN_W   = 12;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int INV_W      = 58;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 58;

  // Fixed arithmetic constants.
  localparam int INV_SCALE_BITS = 56;
  localparam int WEIGHT_LIMIT_LOG2 = 60;
  localparam int SAT_W = WEIGHT_LIMIT_LOG2 + 2;
  localparam int MAX_CH = 255;

  // Parameter defaults.
  localparam int DEF_COORD_FRAC_BITS  = 4;
  localparam int DEF_PIXEL_COORD_BITS = 12;
  localparam int DEF_WEIGHT_FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_X   = 3'd0,
    REG_HUE_Y   = 3'd1,
    REG_WHITE_X = 3'd2,
    REG_WHITE_Y = 3'd3,
    REG_BLACK_X = 3'd4,
    REG_BLACK_Y = 3'd5,
    REG_HUE_RGB = 3'd6,
    REG_INV_AREA = 3'd7
  } btcs_reg_t;

  // Triangle set-up as seen by the datapath.
  typedef struct packed {
    logic [CORNER_W-1:0] hue_x;
    logic [CORNER_W-1:0] hue_y;
    logic [EDGE_W-1:0]   e0x;
    logic [EDGE_W-1:0]   e0y;
    logic [EDGE_W-1:0]   e1x;
    logic [EDGE_W-1:0]   e1y;
    logic [RGB_W-1:0]    hue_rgb;
    logic [INV_W-1:0]    inv_area;
    logic                degenerate;
  } btcs_cfg_t;

endpackage

@@ hw/rtl/barycentric_triangle_color_shader_unit.sv @@
// Top level of the barycentric triangle colour shader.
// Depends on btcs_pkg, btcs_cfg_regs, btcs_edge_pipe, btcs_weight_pipe, btcs_blend_stage.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   input     in_pixel_x, in_pixel_y                  start high, busy low
//   result    out_covered, out_red/green/blue         out_strobe, one cycle
//   config    cfg_index, cfg_data                     cfg_valid and cfg_ready
//
// One pixel transaction is accepted every clock; busy never rises. A result appears
// on out_strobe once its transaction has passed the eight register stages of the
// datapath (pixel offset, edge products, cross products, split inverse-area
// multiplies, rounding, saturation, coverage and blend). Reset clears the
// configuration registers and the pipeline valid bits. The receiver cannot stall,
// so the pipeline never holds; configuration is accepted every cycle. The user must
// write it only while no transaction is in flight; the block does not enforce this.
module barycentric_triangle_color_shader_unit #(
  parameter int COORD_FRAC_BITS  = btcs_pkg::DEF_COORD_FRAC_BITS,
  parameter int PIXEL_COORD_BITS = btcs_pkg::DEF_PIXEL_COORD_BITS,
  parameter int WEIGHT_FRAC_BITS = btcs_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [btcs_pkg::PIX_IN_W-1:0]   in_pixel_x,
  input  logic [btcs_pkg::PIX_IN_W-1:0]   in_pixel_y,
  output logic                            out_strobe,
  output logic                            out_covered,
  output logic [btcs_pkg::CH_W-1:0]       out_red,
  output logic [btcs_pkg::CH_W-1:0]       out_green,
  output logic [btcs_pkg::CH_W-1:0]       out_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import btcs_pkg::*;

  localparam int PX_USE  = (PIXEL_COORD_BITS < PIX_IN_W) ? PIXEL_COORD_BITS : PIX_IN_W;
  localparam int PX_W    = PX_USE + COORD_FRAC_BITS;
  localparam int EP_W    = ((PX_W > CORNER_W - 1) ? PX_W : CORNER_W - 1) + 2;
  localparam int CROSS_W = EP_W + EDGE_W + 1;

  btcs_cfg_t                   cfg;
  logic                        in_valid;
  logic                        cross_valid;
  logic signed [CROSS_W-1:0]   cross_u, cross_v;
  logic                        wt_valid, wt_covered;
  logic [WEIGHT_FRAC_BITS:0]   wt_u, wt_w;

  // The pipeline takes a new transaction in every cycle.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  btcs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_out   (cfg)
  );

  btcs_edge_pipe #(
    .COORD_FRAC_BITS  (COORD_FRAC_BITS),
    .PIXEL_COORD_BITS (PIXEL_COORD_BITS),
    .CROSS_W          (CROSS_W)
  ) u_edge_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .cfg         (cfg),
    .cross_valid (cross_valid),
    .cross_u     (cross_u),
    .cross_v     (cross_v)
  );

  btcs_weight_pipe #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .CROSS_W          (CROSS_W)
  ) u_weight_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .cross_valid (cross_valid),
    .cross_u     (cross_u),
    .cross_v     (cross_v),
    .cfg         (cfg),
    .wt_valid    (wt_valid),
    .wt_covered  (wt_covered),
    .wt_u        (wt_u),
    .wt_w        (wt_w)
  );

  btcs_blend_stage #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_blend_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .wt_valid    (wt_valid),
    .wt_covered  (wt_covered),
    .wt_u        (wt_u),
    .wt_w        (wt_w),
    .cfg         (cfg),
    .out_strobe  (out_strobe),
    .out_covered (out_covered),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule

@@ hw/rtl/btcs_cfg_regs.sv @@
// Configuration register file and derived triangle edge vectors.
// Depends on btcs_pkg.
module btcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [btcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output btcs_pkg::btcs_cfg_t            cfg_out
);
  import btcs_pkg::*;

  logic [CORNER_W-1:0] hue_x_r, hue_y_r, white_x_r, white_y_r, black_x_r, black_y_r;
  logic [RGB_W-1:0]    hue_rgb_r;
  logic [INV_W-1:0]    inv_area_r;
  logic [EDGE_W-1:0]   e0x_r, e0y_r, e1x_r, e1y_r;
  logic                degenerate_r;
  logic [EDGE_W-1:0]   e0x_nxt, e0y_nxt, e1x_nxt, e1y_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_x_r    <= '0;
      hue_y_r    <= '0;
      white_x_r  <= '0;
      white_y_r  <= '0;
      black_x_r  <= '0;
      black_y_r  <= '0;
      hue_rgb_r  <= '0;
      inv_area_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (btcs_reg_t'(cfg_index))
        REG_HUE_X:    hue_x_r    <= cfg_data[CORNER_W-1:0];
        REG_HUE_Y:    hue_y_r    <= cfg_data[CORNER_W-1:0];
        REG_WHITE_X:  white_x_r  <= cfg_data[CORNER_W-1:0];
        REG_WHITE_Y:  white_y_r  <= cfg_data[CORNER_W-1:0];
        REG_BLACK_X:  black_x_r  <= cfg_data[CORNER_W-1:0];
        REG_BLACK_Y:  black_y_r  <= cfg_data[CORNER_W-1:0];
        REG_HUE_RGB:  hue_rgb_r  <= cfg_data[RGB_W-1:0];
        REG_INV_AREA: inv_area_r <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge vectors relative to the hue corner; they are registered, so they take up
  // new corner values in the cycle after the corner registers are written.
  always_comb begin
    e0x_nxt = EDGE_W'($signed(white_x_r)) - EDGE_W'($signed(hue_x_r));
    e0y_nxt = EDGE_W'($signed(white_y_r)) - EDGE_W'($signed(hue_y_r));
    e1x_nxt = EDGE_W'($signed(black_x_r)) - EDGE_W'($signed(hue_x_r));
    e1y_nxt = EDGE_W'($signed(black_y_r)) - EDGE_W'($signed(hue_y_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0x_r        <= '0;
      e0y_r        <= '0;
      e1x_r        <= '0;
      e1y_r        <= '0;
      degenerate_r <= 1'b1;
    end else begin
      e0x_r        <= e0x_nxt;
      e0y_r        <= e0y_nxt;
      e1x_r        <= e1x_nxt;
      e1y_r        <= e1y_nxt;
      degenerate_r <= (inv_area_r == '0);
    end
  end

  always_comb begin
    cfg_out.hue_x      = hue_x_r;
    cfg_out.hue_y      = hue_y_r;
    cfg_out.e0x        = e0x_r;
    cfg_out.e0y        = e0y_r;
    cfg_out.e1x        = e1x_r;
    cfg_out.e1y        = e1y_r;
    cfg_out.hue_rgb    = hue_rgb_r;
    cfg_out.inv_area   = inv_area_r;
    cfg_out.degenerate = degenerate_r;
  end

endmodule

@@ hw/rtl/btcs_edge_pipe.sv @@
// Pipeline stages one to three: pixel offset, edge products and cross products.
// Depends on btcs_pkg.
module btcs_edge_pipe #(
  parameter int COORD_FRAC_BITS  = btcs_pkg::DEF_COORD_FRAC_BITS,
  parameter int PIXEL_COORD_BITS = btcs_pkg::DEF_PIXEL_COORD_BITS,
  parameter int CROSS_W          = 37
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [btcs_pkg::PIX_IN_W-1:0] pixel_x,
  input  logic [btcs_pkg::PIX_IN_W-1:0] pixel_y,
  input  btcs_pkg::btcs_cfg_t           cfg,
  output logic                          cross_valid,
  output logic signed [CROSS_W-1:0]     cross_u,
  output logic signed [CROSS_W-1:0]     cross_v
);
  import btcs_pkg::*;

  localparam int PX_USE = (PIXEL_COORD_BITS < PIX_IN_W) ? PIXEL_COORD_BITS : PIX_IN_W;
  localparam int PX_W   = PX_USE + COORD_FRAC_BITS;
  localparam int EP_W   = ((PX_W > CORNER_W - 1) ? PX_W : CORNER_W - 1) + 2;
  localparam int PROD_W = EP_W + EDGE_W;

  logic                     v1_r, v2_r, v3_r;
  logic [PX_W-1:0]          px, py;
  logic signed [EP_W-1:0]   epx_nxt, epy_nxt, epx_r, epy_r;
  logic signed [PROD_W-1:0] ma_r, mb_r, mc_r, md_r;
  logic signed [PROD_W-1:0] ma_nxt, mb_nxt, mc_nxt, md_nxt;
  logic signed [CROSS_W-1:0] cu_r, cv_r;
  logic signed [EDGE_W-1:0] e0x, e0y, e1x, e1y;

  always_comb begin
    px      = PX_W'(pixel_x[PX_USE-1:0]) << COORD_FRAC_BITS;
    py      = PX_W'(pixel_y[PX_USE-1:0]) << COORD_FRAC_BITS;
    epx_nxt = EP_W'($signed({1'b0, px})) - EP_W'($signed(cfg.hue_x));
    epy_nxt = EP_W'($signed({1'b0, py})) - EP_W'($signed(cfg.hue_y));
    e0x     = $signed(cfg.e0x);
    e0y     = $signed(cfg.e0y);
    e1x     = $signed(cfg.e1x);
    e1y     = $signed(cfg.e1y);
    ma_nxt  = PROD_W'(epx_r) * PROD_W'(e1y);
    mb_nxt  = PROD_W'(epy_r) * PROD_W'(e1x);
    mc_nxt  = PROD_W'(e0x) * PROD_W'(epy_r);
    md_nxt  = PROD_W'(e0y) * PROD_W'(epx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    epx_r <= epx_nxt;
    epy_r <= epy_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    mc_r  <= mc_nxt;
    md_r  <= md_nxt;
    cu_r  <= CROSS_W'(ma_r) - CROSS_W'(mb_r);
    cv_r  <= CROSS_W'(mc_r) - CROSS_W'(md_r);
  end

  assign cross_valid = v3_r;
  assign cross_u     = cu_r;
  assign cross_v     = cv_r;

endmodule

@@ hw/rtl/btcs_weight_pipe.sv @@
// Pipeline stages four to seven: scaling by the inverse area, rounding,
// saturation, hue weight, coverage test and weight clamping. Depends on btcs_pkg.
module btcs_weight_pipe #(
  parameter int WEIGHT_FRAC_BITS = btcs_pkg::DEF_WEIGHT_FRAC_BITS,
  parameter int CROSS_W          = 37
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cross_valid,
  input  logic signed [CROSS_W-1:0]   cross_u,
  input  logic signed [CROSS_W-1:0]   cross_v,
  input  btcs_pkg::btcs_cfg_t         cfg,
  output logic                        wt_valid,
  output logic                        wt_covered,
  output logic [WEIGHT_FRAC_BITS:0]   wt_u,
  output logic [WEIGHT_FRAC_BITS:0]   wt_w
);
  import btcs_pkg::*;

  localparam int INV_LO_W = INV_W / 2;
  localparam int INV_HI_W = INV_W - INV_LO_W;
  localparam int PLO_W    = CROSS_W + INV_LO_W + 1;
  localparam int PHI_W    = CROSS_W + INV_HI_W;
  localparam int FULL_W   = CROSS_W + INV_W;
  localparam int SHIFT    = INV_SCALE_BITS - WEIGHT_FRAC_BITS;
  localparam int RW       = FULL_W - SHIFT;
  localparam int CMP_W    = (RW > SAT_W) ? RW : SAT_W;
  localparam int W_W      = SAT_W + 2;
  localparam int EPS      = ((1 << WEIGHT_FRAC_BITS) + 5000) / 10000;

  localparam logic signed [CMP_W-1:0] LIM_POS = CMP_W'(1) <<< WEIGHT_LIMIT_LOG2;
  localparam logic signed [CMP_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [FULL_W-1:0] HALF   = FULL_W'(1) <<< (SHIFT - 1);
  localparam logic signed [W_W-1:0] ONE_W     = W_W'(1) <<< WEIGHT_FRAC_BITS;
  localparam logic signed [W_W-1:0] NEG_EPS   = -(W_W'(EPS));
  localparam logic signed [SAT_W-1:0] ONE_S   = SAT_W'(1) <<< WEIGHT_FRAC_BITS;
  localparam logic signed [SAT_W-1:0] NEG_EPS_S = -(SAT_W'(EPS));

  logic v4_r, v5_r, v6_r, v7_r;

  // Stage four: the inverse area is split into two halves so that each
  // multiplier stays near 32 bits.
  logic signed [INV_HI_W-1:0] inv_hi;
  logic signed [INV_LO_W:0]   inv_lo;
  logic signed [PLO_W-1:0]    ulo_r, vlo_r;
  logic signed [PHI_W-1:0]    uhi_r, vhi_r;

  // Stage five: recombine and round half up.
  logic signed [FULL_W-1:0] ufull, vfull, urnd_full, vrnd_full;
  logic signed [RW-1:0]     urnd_r, vrnd_r;

  // Stage six: saturate.
  logic signed [CMP_W-1:0]  uext, vext;
  logic signed [SAT_W-1:0]  usat_nxt, vsat_nxt, usat_r, vsat_r;

  // Stage seven: hue weight, coverage and clamping.
  logic signed [W_W-1:0]     w_full;
  logic                      cov_nxt, cov_r;
  logic [WEIGHT_FRAC_BITS:0] uc_nxt, wc_nxt, uc_r, wc_r;

  always_comb begin
    inv_hi = $signed(cfg.inv_area[INV_W-1:INV_LO_W]);
    inv_lo = $signed({1'b0, cfg.inv_area[INV_LO_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= cross_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_comb begin
    ufull     = {uhi_r, {INV_LO_W{1'b0}}} + FULL_W'(ulo_r);
    vfull     = {vhi_r, {INV_LO_W{1'b0}}} + FULL_W'(vlo_r);
    urnd_full = ufull + HALF;
    vrnd_full = vfull + HALF;
  end

  always_comb begin
    uext = CMP_W'(urnd_r);
    vext = CMP_W'(vrnd_r);
    if (uext > LIM_POS) begin
      usat_nxt = SAT_W'(LIM_POS);
    end else if (uext < LIM_NEG) begin
      usat_nxt = SAT_W'(LIM_NEG);
    end else begin
      usat_nxt = uext[SAT_W-1:0];
    end
    if (vext > LIM_POS) begin
      vsat_nxt = SAT_W'(LIM_POS);
    end else if (vext < LIM_NEG) begin
      vsat_nxt = SAT_W'(LIM_NEG);
    end else begin
      vsat_nxt = vext[SAT_W-1:0];
    end
  end

  always_comb begin
    w_full  = ONE_W - W_W'(usat_r) - W_W'(vsat_r);
    cov_nxt = !cfg.degenerate && (usat_r >= NEG_EPS_S) && (vsat_r >= NEG_EPS_S)
              && (w_full >= NEG_EPS);
    if (usat_r < 0) begin
      uc_nxt = '0;
    end else if (usat_r > ONE_S) begin
      uc_nxt = ONE_S[WEIGHT_FRAC_BITS:0];
    end else begin
      uc_nxt = usat_r[WEIGHT_FRAC_BITS:0];
    end
    if (w_full < 0) begin
      wc_nxt = '0;
    end else if (w_full > ONE_W) begin
      wc_nxt = ONE_W[WEIGHT_FRAC_BITS:0];
    end else begin
      wc_nxt = w_full[WEIGHT_FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    ulo_r  <= PLO_W'(cross_u) * PLO_W'(inv_lo);
    vlo_r  <= PLO_W'(cross_v) * PLO_W'(inv_lo);
    uhi_r  <= PHI_W'(cross_u) * PHI_W'(inv_hi);
    vhi_r  <= PHI_W'(cross_v) * PHI_W'(inv_hi);
    urnd_r <= urnd_full[FULL_W-1:SHIFT];
    vrnd_r <= vrnd_full[FULL_W-1:SHIFT];
    usat_r <= usat_nxt;
    vsat_r <= vsat_nxt;
    cov_r  <= cov_nxt;
    uc_r   <= uc_nxt;
    wc_r   <= wc_nxt;
  end

  assign wt_valid   = v7_r;
  assign wt_covered = cov_r;
  assign wt_u       = uc_r;
  assign wt_w       = wc_r;

endmodule

@@ hw/rtl/btcs_blend_stage.sv @@
// Final pipeline stage: per-channel colour blend, rounding, clamping and the
// output register. Depends on btcs_pkg.
module btcs_blend_stage #(
  parameter int WEIGHT_FRAC_BITS = btcs_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wt_valid,
  input  logic                        wt_covered,
  input  logic [WEIGHT_FRAC_BITS:0]   wt_u,
  input  logic [WEIGHT_FRAC_BITS:0]   wt_w,
  input  btcs_pkg::btcs_cfg_t         cfg,
  output logic                        out_strobe,
  output logic                        out_covered,
  output logic [btcs_pkg::CH_W-1:0]   out_red,
  output logic [btcs_pkg::CH_W-1:0]   out_green,
  output logic [btcs_pkg::CH_W-1:0]   out_blue
);
  import btcs_pkg::*;

  localparam int ACC_W = WEIGHT_FRAC_BITS + CH_W + 2;
  localparam int Q_W   = ACC_W - WEIGHT_FRAC_BITS;

  function automatic logic [CH_W-1:0] blend_ch(input logic [WEIGHT_FRAC_BITS:0] w,
                                               input logic [WEIGHT_FRAC_BITS:0] u,
                                               input logic [CH_W-1:0] c);
    logic [ACC_W-1:0] acc;
    logic [Q_W-1:0]   q;
    acc = ACC_W'(w) * ACC_W'(c) + ACC_W'(u) * ACC_W'(MAX_CH)
          + (ACC_W'(1) << (WEIGHT_FRAC_BITS - 1));
    q = acc[ACC_W-1:WEIGHT_FRAC_BITS];
    if (q > Q_W'(MAX_CH)) begin
      return CH_W'(MAX_CH);
    end
    return q[CH_W-1:0];
  endfunction

  logic            strobe_r, cov_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;

  // Uncovered pixels report black.
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (wt_covered) begin
      red_nxt   = blend_ch(wt_w, wt_u, cfg.hue_rgb[3*CH_W-1:2*CH_W]);
      green_nxt = blend_ch(wt_w, wt_u, cfg.hue_rgb[2*CH_W-1:CH_W]);
      blue_nxt  = blend_ch(wt_w, wt_u, cfg.hue_rgb[CH_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= wt_valid;
    end
  end

  always_ff @(posedge clk) begin
    cov_r   <= wt_covered;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_strobe  = strobe_r;
  assign out_covered = cov_r;
  assign out_red     = red_r;
  assign out_green   = green_r;
  assign out_blue    = blue_r;

endmodule

@@ test/btcs_shade_checker.sv @@
// Scoreboard for the barycentric triangle colour shader: mirrors the register
// file, predicts the shade of every accepted pixel and compares each result strobe.
// Depends on btcs_pkg for widths, register indexes and arithmetic constants.
`timescale 1ns / 1ps

module btcs_shade_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [btcs_pkg::PIX_IN_W-1:0]   in_pixel_x,
  input  logic [btcs_pkg::PIX_IN_W-1:0]   in_pixel_y,
  input  logic                            out_strobe,
  input  logic                            out_covered,
  input  logic [btcs_pkg::CH_W-1:0]       out_red,
  input  logic [btcs_pkg::CH_W-1:0]       out_green,
  input  logic [btcs_pkg::CH_W-1:0]       out_blue,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [btcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              outstanding,
  output int                              mismatches
);
  import btcs_pkg::*;

  localparam int     WFRAC  = DEF_WEIGHT_FRAC_BITS;
  localparam int     WSHIFT = INV_SCALE_BITS - WFRAC;
  localparam longint WONE   = longint'(1) << WFRAC;
  // Coverage tolerance of one ten-thousandth, rounded to the weight grid.
  localparam longint WEPS   = (WONE + 5000) / 10000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic            covered;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } shade_t;

  shade_t expected_shades[$];

  logic signed [CORNER_W-1:0] hue_x, hue_y, white_x, white_y, black_x, black_y;
  logic [RGB_W-1:0]           hue_rgb;
  logic signed [INV_W-1:0]    inv_area;

  // Cross product times the reciprocal area, rounded half up onto the weight
  // grid and saturated to the weight limit.
  function automatic wide_t scaled_weight(input wide_t edge_cross);
    wide_t prod, q, lim;
    lim  = wide_t'(1) <<< WEIGHT_LIMIT_LOG2;
    prod = edge_cross * wide_t'(inv_area);
    q    = (prod + (wide_t'(1) <<< (WSHIFT - 1))) >>> WSHIFT;
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

  function automatic logic [CH_W-1:0] blend_channel(input wide_t w, input wide_t u,
                                                    input logic [CH_W-1:0] hue);
    wide_t acc;
    acc = (w * wide_t'({1'b0, hue}) + u * MAX_CH + (wide_t'(1) <<< (WFRAC - 1))) >>> WFRAC;
    return (acc > MAX_CH) ? CH_W'(MAX_CH) : acc[CH_W-1:0];
  endfunction

  function automatic shade_t shade_pixel(input logic [PIX_IN_W-1:0] x,
                                         input logic [PIX_IN_W-1:0] y);
    wide_t epx, epy, e0x, e0y, e1x, e1y, u, v, w;
    shade_t s;
    s   = '0;
    epx = (wide_t'(x) <<< DEF_COORD_FRAC_BITS) - wide_t'(hue_x);
    epy = (wide_t'(y) <<< DEF_COORD_FRAC_BITS) - wide_t'(hue_y);
    e0x = wide_t'(white_x) - wide_t'(hue_x);
    e0y = wide_t'(white_y) - wide_t'(hue_y);
    e1x = wide_t'(black_x) - wide_t'(hue_x);
    e1y = wide_t'(black_y) - wide_t'(hue_y);
    // A zero reciprocal marks a degenerate triangle, which covers nothing.
    if (inv_area == 0) return s;
    u = scaled_weight(epx * e1y - epy * e1x);
    v = scaled_weight(e0x * epy - e0y * epx);
    w = wide_t'(WONE) - u - v;
    if (u < -WEPS || v < -WEPS || w < -WEPS) return s;
    if (u < 0) u = 0;
    if (u > WONE) u = WONE;
    if (w < 0) w = 0;
    if (w > WONE) w = WONE;
    // The black corner contributes nothing to the blend.
    s.covered = 1'b1;
    s.red     = blend_channel(w, u, hue_rgb[23:16]);
    s.green   = blend_channel(w, u, hue_rgb[15:8]);
    s.blue    = blend_channel(w, u, hue_rgb[7:0]);
    return s;
  endfunction

  task automatic report_mismatch(input string line);
    $display("%0t shade mismatch: %s", $time, line);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    shade_t want;
    if (!rst_n) begin
      hue_x    <= '0;
      hue_y    <= '0;
      white_x  <= '0;
      white_y  <= '0;
      black_x  <= '0;
      black_y  <= '0;
      hue_rgb  <= '0;
      inv_area <= '0;
      expected_shades.delete();
    end else begin
      if (out_strobe) begin
        if (expected_shades.size() == 0) begin
          report_mismatch($sformatf("result (covered %0b rgb %02h%02h%02h) with none outstanding",
                                    out_covered, out_red, out_green, out_blue));
        end else begin
          want = expected_shades.pop_front();
          if (out_covered !== want.covered)
            report_mismatch($sformatf("covered got %0b expected %0b", out_covered, want.covered));
          if (out_red !== want.red)
            report_mismatch($sformatf("red got %0d expected %0d", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("green got %0d expected %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue got %0d expected %0d", out_blue, want.blue));
        end
      end
      // Prediction uses the registers as they stand before this edge's write.
      if (start && !busy) begin
        expected_shades.push_back(shade_pixel(in_pixel_x, in_pixel_y));
      end
      if (cfg_valid && cfg_ready) begin
        case (btcs_reg_t'(cfg_index))
          REG_HUE_X:    hue_x    <= cfg_data[CORNER_W-1:0];
          REG_HUE_Y:    hue_y    <= cfg_data[CORNER_W-1:0];
          REG_WHITE_X:  white_x  <= cfg_data[CORNER_W-1:0];
          REG_WHITE_Y:  white_y  <= cfg_data[CORNER_W-1:0];
          REG_BLACK_X:  black_x  <= cfg_data[CORNER_W-1:0];
          REG_BLACK_Y:  black_y  <= cfg_data[CORNER_W-1:0];
          REG_HUE_RGB:  hue_rgb  <= cfg_data[RGB_W-1:0];
          REG_INV_AREA: inv_area <= cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_shades.size();
  end

endmodule

@@ test/tb.sv @@
// Top of the shader regression: clock, reset, triangle programming and pixel
// stimulus with random idling. Depends on btcs_pkg, the shader top level and btcs_shade_checker.
`timescale 1ns / 1ps

module tb;
  import btcs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS  = 50;
  localparam int PIXEL_MAX     = (1 << PIX_IN_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PIX_IN_W-1:0]   in_pixel_x = '0;
  logic [PIX_IN_W-1:0]   in_pixel_y = '0;
  logic                  out_strobe;
  logic                  out_covered;
  logic [CH_W-1:0]       out_red, out_green, out_blue;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int box_x0, box_x1, box_y0, box_y1;

  always #2 clk = ~clk;

  barycentric_triangle_color_shader_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .out_strobe  (out_strobe),
    .out_covered (out_covered),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  btcs_shade_checker shade_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .out_strobe  (out_strobe),
    .out_covered (out_covered),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pixel_clip(input int v);
    if (v < 0) return 0;
    return (v > PIXEL_MAX) ? PIXEL_MAX : v;
  endfunction

  function automatic int span_lo(input int a, input int b, input int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int span_hi(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // A corner within the given number of pixels of a pixel centre, kept inside
  // the 17-bit signed corner range.
  function automatic int corner_near(input int c, input int spread);
    int v;
    v = c * 16 + int'($urandom_range(0, 32 * spread)) - 16 * spread;
    if (v < -65536) v = -65536;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  task automatic write_reg(input btcs_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Programs all eight registers. Unless a reciprocal is forced, the area
  // reciprocal is derived from the corners so that the triangle is consistent.
  task automatic set_corners(input int hx, input int hy, input int wx, input int wy,
                             input int bx, input int by, input logic [RGB_W-1:0] rgb,
                             input bit force_recip, input logic [CFG_DATA_W-1:0] forced);
    longint area2, mag, recip;
    area2 = longint'(wx - hx) * (by - hy) - longint'(wy - hy) * (bx - hx);
    mag   = (area2 < 0) ? -area2 : area2;
    recip = 0;
    if (area2 != 0) begin
      recip = ((longint'(1) <<< INV_SCALE_BITS) + mag / 2) / mag;
      if (area2 < 0) recip = -recip;
    end
    write_reg(REG_HUE_X, CFG_DATA_W'(hx));
    write_reg(REG_HUE_Y, CFG_DATA_W'(hy));
    write_reg(REG_WHITE_X, CFG_DATA_W'(wx));
    write_reg(REG_WHITE_Y, CFG_DATA_W'(wy));
    write_reg(REG_BLACK_X, CFG_DATA_W'(bx));
    write_reg(REG_BLACK_Y, CFG_DATA_W'(by));
    write_reg(REG_HUE_RGB, CFG_DATA_W'(rgb));
    write_reg(REG_INV_AREA, force_recip ? forced : CFG_DATA_W'(recip));
    cfg_valid <= 1'b0;
    box_x0 = pixel_clip(span_lo(hx, wx, bx) >>> DEF_COORD_FRAC_BITS);
    box_x1 = pixel_clip((span_hi(hx, wx, bx) + 15) >>> DEF_COORD_FRAC_BITS);
    box_y0 = pixel_clip(span_lo(hy, wy, by) >>> DEF_COORD_FRAC_BITS);
    box_y1 = pixel_clip((span_hi(hy, wy, by) + 15) >>> DEF_COORD_FRAC_BITS);
  endtask

  task automatic send_pixel(input logic [PIX_IN_W-1:0] x, input logic [PIX_IN_W-1:0] y);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start      <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding shade has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int cx, cy, spread;
    logic [PIX_IN_W-1:0] x, y;
    logic [CFG_DATA_W-1:0] recip;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at reset describe a degenerate triangle.
    send_pixel(0, 0);
    send_pixel(PIX_IN_W'(PIXEL_MAX), PIX_IN_W'(PIXEL_MAX));
    send_pixel(12'hAAA, 12'h555);
    drain();

    // Right triangle with legs of 100 pixels: each corner, an edge, the interior and points outside.
    set_corners(0, 0, 1600, 0, 0, 1600, 24'h40C080, 1'b0, '0);
    send_pixel(0, 0);
    send_pixel(100, 0);
    send_pixel(0, 100);
    send_pixel(50, 50);
    send_pixel(51, 50);
    send_pixel(33, 33);
    send_pixel(PIX_IN_W'(PIXEL_MAX), PIX_IN_W'(PIXEL_MAX));
    send_pixel(10, 10);
    drain();

    // Corners at the far ends of their range.
    set_corners(-65536, -65536, 65535, -65536, -65536, 65535, 24'hFFFFFF, 1'b0, '0);
    send_pixel(0, 0);
    send_pixel(PIX_IN_W'(PIXEL_MAX), PIX_IN_W'(PIXEL_MAX));
    send_pixel(PIX_IN_W'(PIXEL_MAX), 0);
    send_pixel(0, PIX_IN_W'(PIXEL_MAX));
    send_pixel(2047, 2048);
    drain();

    // Clockwise winding gives a negative reciprocal.
    set_corners(160, 160, 160, 800, 800, 160, 24'h000000, 1'b0, '0);
    send_pixel(10, 10);
    send_pixel(20, 20);
    send_pixel(15, 20);
    send_pixel(40, 40);
    drain();

    // Smallest possible area, then reciprocals at both extremes of the register.
    set_corners(0, 0, 1, 0, 0, 1, 24'h123456, 1'b0, '0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    drain();
    set_corners(0, 0, 1, 0, 0, 1, 24'h123456, 1'b1, {2'b11, 56'd0});
    send_pixel(0, 0);
    send_pixel(0, 1);
    drain();
    set_corners(0, 0, 1, 0, 0, 1, 24'hFEDCBA, 1'b1, {1'b1, 57'd0});
    send_pixel(2, 2);
    drain();
    set_corners(0, 0, 1, 0, 0, 1, 24'hFEDCBA, 1'b1, {1'b0, {57{1'b1}}});
    send_pixel(0, 0);
    send_pixel(PIX_IN_W'(PIXEL_MAX), PIX_IN_W'(PIXEL_MAX));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      quiet  = (p == 6 || p == 7);
      cx     = $urandom_range(0, PIXEL_MAX);
      cy     = $urandom_range(0, PIXEL_MAX);
      spread = (p % 4 == 2) ? $urandom_range(64, 2048) : $urandom_range(1, 40);
      // Some phases carry a reciprocal that does not match the corners, and
      // some a zero reciprocal.
      recip  = (p % 6 == 5) ? '0 : CFG_DATA_W'({$urandom, $urandom});
      set_corners(corner_near(cx, spread), corner_near(cy, spread),
                  corner_near(cx, spread), corner_near(cy, spread),
                  corner_near(cx, spread), corner_near(cy, spread),
                  RGB_W'($urandom), (p % 6 == 3 || p % 6 == 5), recip);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if ($urandom_range(0, 99) < 75) begin
          x = PIX_IN_W'($urandom_range(box_x0, box_x1));
          y = PIX_IN_W'($urandom_range(box_y0, box_y1));
        end else begin
          x = PIX_IN_W'($urandom);
          y = PIX_IN_W'($urandom);
        end
        send_pixel(x, y);
        if ($urandom_range(0, 99) < 2) drain();
      end
    end
    quiet = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
